// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Every macro expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: invariant violated");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle implication violated");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication violated");

`endif

// File: hw/rtl/pclr_pkg.sv
`timescale 1ns / 1ps

package pclr_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int COLOR_BITS = 32;
  localparam int DATA_BITS  = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int PAD_BITS   = DATA_BITS - 2 * COORD_BITS - COLOR_BITS;

  typedef enum logic [1:0] {
    OP_MOVE_TO = 2'd0,
    OP_LINE_TO = 2'd1,
    OP_CLOSE   = 2'd2,
    OP_STEP    = 2'd3
  } op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t                      walk_x;
    coord_t                      walk_y;
    coord_t                      end_x;
    coord_t                      end_y;
    logic [COORD_BITS-1:0]       delta_x;
    logic [COORD_BITS-1:0]       delta_y;
    logic                        x_neg;
    logic                        y_neg;
    logic signed [ERR_BITS-1:0]  err;
  } line_t;

endpackage

// File: hw/rtl/pclr_line_step.sv
`timescale 1ns / 1ps

module pclr_line_step (
  input  pclr_pkg::line_t cur,
  output pclr_pkg::line_t nxt,
  output logic            last
);

  logic signed [pclr_pkg::ERR_BITS:0] e2;
  logic signed [pclr_pkg::ERR_BITS:0] dx_w;
  logic signed [pclr_pkg::ERR_BITS:0] dy_w;
  logic signed [pclr_pkg::ERR_BITS:0] err_w;
  logic signed [pclr_pkg::ERR_BITS:0] err_sum;
  logic                               move_x;
  logic                               move_y;

  always_comb begin
    last    = (cur.walk_x == cur.end_x) && (cur.walk_y == cur.end_y);
    e2      = {cur.err, 1'b0};
    dx_w    = $signed({3'b000, cur.delta_x});
    dy_w    = $signed({3'b000, cur.delta_y});
    err_w   = {cur.err[pclr_pkg::ERR_BITS-1], cur.err};
    move_x  = e2 > -dy_w;
    move_y  = e2 < dx_w;
    err_sum = err_w;
    if (move_x) begin
      err_sum = err_sum - dy_w;
    end
    if (move_y) begin
      err_sum = err_sum + dx_w;
    end
    nxt     = cur;
    nxt.err = err_sum[pclr_pkg::ERR_BITS-1:0];
    if (move_x) begin
      nxt.walk_x = cur.x_neg ? cur.walk_x - pclr_pkg::COORD_BITS'(1)
                             : cur.walk_x + pclr_pkg::COORD_BITS'(1);
    end
    if (move_y) begin
      nxt.walk_y = cur.y_neg ? cur.walk_y - pclr_pkg::COORD_BITS'(1)
                             : cur.walk_y + pclr_pkg::COORD_BITS'(1);
    end
  end

endmodule

// File: hw/rtl/polygon_contour_line_rasterizer.sv
`timescale 1ns / 1ps
// Polygon contour rasteriser built on Bresenham line stepping.
// Input words arrive on the s_axis channel: tuser carries the command (move_to, line_to,
// close, step) and tdata carries the vertex and the drawing colour. Each step command
// taken while a line is active yields one pixel word on the m_axis channel; tlast marks
// the final pixel of the line. Other commands yield nothing, and move_to, line_to and close
// commands that arrive while a line is still being drawn are dropped.
// A word is held in an input register, then a single add-and-compare error update moves
// the line and loads the output register, so each pixel passes through both registers
// on its way to m_axis. One word per cycle is sustained while the receiver does not
// stall, which is one pixel per clock while the line runs.
// When the receiver stalls, the pending pixel stays in the output register and the
// next step word waits in the input register; s_axis_tready falls only then. Words that
// yield no pixel keep flowing during a stall.
// A synchronous reset empties both registers, ends any line, and sets the first and
// current vertex to the origin and the latched colour to zero.

`include "assert_macros.svh"

module polygon_contour_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // vertex_x, vertex_y, draw_color
  input  logic [pclr_pkg::DATA_BITS-1:0] s_axis_tdata,
  // op
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [pclr_pkg::DATA_BITS-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int CB = pclr_pkg::COORD_BITS;
  localparam int EB = pclr_pkg::ERR_BITS;

  logic                              in_valid;
  pclr_pkg::op_t                     in_op;
  pclr_pkg::coord_t                  in_x;
  pclr_pkg::coord_t                  in_y;
  logic [pclr_pkg::COLOR_BITS-1:0]   in_color;

  pclr_pkg::coord_t                  first_x;
  pclr_pkg::coord_t                  first_y;
  pclr_pkg::coord_t                  current_x;
  pclr_pkg::coord_t                  current_y;
  logic [pclr_pkg::COLOR_BITS-1:0]   latched_color;
  pclr_pkg::line_t                   line;
  logic                              line_active;

  logic                              out_valid;
  pclr_pkg::coord_t                  out_x;
  pclr_pkg::coord_t                  out_y;
  logic [pclr_pkg::COLOR_BITS-1:0]   out_color;
  logic                              out_last;

  pclr_pkg::line_t                   line_stepped;
  logic                              step_last;
  pclr_pkg::line_t                   line_begin;
  pclr_pkg::coord_t                  target_x;
  pclr_pkg::coord_t                  target_y;
  logic signed [CB:0]                diff_x;
  logic signed [CB:0]                diff_y;
  logic signed [CB:0]                abs_x;
  logic signed [CB:0]                abs_y;
  logic                              is_step;
  logic                              emits;
  logic                              advance;
  logic                              load_out;

  pclr_line_step u_step (
    .cur  (line),
    .nxt  (line_stepped),
    .last (step_last)
  );

  always_comb begin
    is_step  = (in_op == pclr_pkg::OP_STEP);
    emits    = is_step && line_active;
    advance  = in_valid && (!emits || !out_valid || m_axis_tready);
    load_out = advance && emits;

    target_x = (in_op == pclr_pkg::OP_CLOSE) ? first_x : in_x;
    target_y = (in_op == pclr_pkg::OP_CLOSE) ? first_y : in_y;
    diff_x   = {target_x[CB-1], target_x} - {current_x[CB-1], current_x};
    diff_y   = {target_y[CB-1], target_y} - {current_y[CB-1], current_y};
    abs_x    = diff_x[CB] ? -diff_x : diff_x;
    abs_y    = diff_y[CB] ? -diff_y : diff_y;

    line_begin.walk_x  = current_x;
    line_begin.walk_y  = current_y;
    line_begin.end_x   = target_x;
    line_begin.end_y   = target_y;
    line_begin.delta_x = abs_x[CB-1:0];
    line_begin.delta_y = abs_y[CB-1:0];
    line_begin.x_neg   = !(current_x < target_x);
    line_begin.y_neg   = !(current_y < target_y);
    line_begin.err     = EB'($signed({2'b00, abs_x[CB-1:0]}) -
                             $signed({2'b00, abs_y[CB-1:0]}));
  end

  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{pclr_pkg::PAD_BITS{1'b0}}, out_color, out_y, out_x};
  assign m_axis_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_op    <= pclr_pkg::op_t'(s_axis_tuser);
      in_x     <= s_axis_tdata[CB-1:0];
      in_y     <= s_axis_tdata[2*CB-1:CB];
      in_color <= s_axis_tdata[2*CB+pclr_pkg::COLOR_BITS-1:2*CB];
    end
    if (load_out) begin
      out_x     <= line.walk_x;
      out_y     <= line.walk_y;
      out_color <= latched_color;
      out_last  <= step_last;
    end
    if (rst) begin
      in_valid      <= 1'b0;
      out_valid     <= 1'b0;
      line_active   <= 1'b0;
      first_x       <= '0;
      first_y       <= '0;
      current_x     <= '0;
      current_y     <= '0;
      latched_color <= '0;
      line          <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (is_step) begin
          if (line_active) begin
            if (step_last) begin
              line_active <= 1'b0;
            end else begin
              line <= line_stepped;
            end
          end
        end else if (!line_active) begin
          if (in_op == pclr_pkg::OP_MOVE_TO) begin
            first_x       <= in_x;
            first_y       <= in_y;
            current_x     <= in_x;
            current_y     <= in_y;
            latched_color <= in_color;
          end else begin
            line        <= line_begin;
            line_active <= 1'b1;
            current_x   <= target_x;
            current_y   <= target_y;
          end
        end
      end
    end
  end

  `ASSERT_IMPLIES(a_pixel_needs_line, load_out, line_active)
  `ASSERT_NEXT(a_last_pixel_ends_line, load_out && step_last, !line_active)
  `ASSERT_IMPLIES(a_out_valid_loaded, $rose(out_valid), $past(load_out))

endmodule
